### design/masked_score_mean_aggregator_defines.svh
// Assertion helpers for the design files; msma_dp includes them
`ifndef MASKED_SCORE_MEAN_AGGREGATOR_DEFINES_SVH
`define MASKED_SCORE_MEAN_AGGREGATOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define MSMA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that holds at the clock edge after the trigger
`define MSMA_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### design/msma_pkg.sv
`default_nettype none

package msma_pkg;

	localparam int SCORE_W     = 16;
	localparam int MAX_QUERIES = 128;
	localparam int CNT_W       = $clog2(MAX_QUERIES + 1);
	localparam int MIN_REQ_W   = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// Square-mode term: floor((|v - 320| + 100)^2 / 100) + 320
	localparam int SQ_CENTER   = 320;
	localparam int SQ_BIAS     = 100;
	localparam int SQ_OFFSET   = 320;
	localparam int PROD_W      = 2 * SCORE_W;
	localparam int TERM_W      = 26;
	localparam int TOTAL_W     = TERM_W + 1;
	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every 32-bit x
	localparam logic [PROD_W-1:0] RECIP_100 = 32'hA3D7_0A3E;
	localparam int RECIP_SHIFT = 38;

	localparam int DIV_STEPS   = SCORE_W;
	localparam int STEP_W      = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_REQUIRED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_MODE  = 1'd1;

	localparam logic [MIN_REQ_W-1:0] MIN_REQ_RESET = 8'd1;
	localparam logic [MIN_REQ_W-1:0] MIN_REQ_TOTAL = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_MUL,
		ST_SQ_DIV,
		ST_ACC,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_EMIT
	} msma_state_t;

	typedef struct packed {
		logic capture;
		logic sq_mul;
		logic sq_div;
		logic acc;
		logic div_start;
		logic out_load;
	} msma_cmd_t;

	typedef struct packed {
		logic square;
		logic last;
		logic zero_res;
		logic div_busy;
		logic out_free;
	} msma_sts_t;

endpackage

`default_nettype wire

### design/msma_in_if.sv
`default_nettype none

interface msma_in_if;
	import msma_pkg::*;

	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;
	logic               last;

	modport source (output valid, output score, output last, input ready);
	modport sink (input valid, input score, input last, output ready);

endinterface

`default_nettype wire

### design/msma_out_if.sv
`default_nettype none

interface msma_out_if;
	import msma_pkg::*;

	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] gene_score;
	logic               sum_wrapped;

	modport source (output valid, output gene_score, output sum_wrapped, input ready);
	modport sink (input valid, input gene_score, input sum_wrapped, output ready);

endinterface

`default_nettype wire

### design/msma_div.sv
`default_nettype none

module msma_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [msma_pkg::SCORE_W-1:0]  dividend,
	input  logic [msma_pkg::CNT_W-1:0]    divisor,
	output logic                          busy,
	output logic [msma_pkg::SCORE_W-1:0]  quotient
);
	import msma_pkg::*;

	logic [STEP_W-1:0]  steps_q;
	logic [SCORE_W-1:0] quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [CNT_W:0]     trial;
	logic [CNT_W:0]     diff;
	logic               fits;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[SCORE_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= STEP_W'(DIV_STEPS);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (steps_q != '0) begin
			quo_q <= {quo_q[SCORE_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign busy     = steps_q != '0;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### design/msma_dp.sv
`default_nettype none

`include "masked_score_mean_aggregator_defines.svh"

module msma_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [msma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msma_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [msma_pkg::SCORE_W-1:0]    score,
	input  logic                            last,
	input  msma_pkg::msma_cmd_t             cmd,
	output msma_pkg::msma_sts_t             sts,
	input  logic                            res_ready,
	output logic                            res_valid,
	output logic [msma_pkg::SCORE_W-1:0]    gene_score,
	output logic                            sum_wrapped
);
	import msma_pkg::*;

	logic [MIN_REQ_W-1:0] min_req_q;
	logic                 square_q;

	logic [SCORE_W-1:0]   score_q;
	logic                 last_q;
	logic [PROD_W-1:0]    prod_q;
	logic [TERM_W-1:0]    term_q;

	logic [SCORE_W-1:0]   sum_q;
	logic [CNT_W-1:0]     nz_q;
	logic [CNT_W-1:0]     items_q;
	logic                 wrap_q;

	logic                 res_valid_q;
	logic [SCORE_W-1:0]   gene_score_q;
	logic                 sum_wrapped_q;

	logic [SCORE_W:0]     dev;
	logic [SCORE_W-1:0]   biased;
	logic [2*PROD_W-1:0]  scaled;
	logic [TERM_W-1:0]    term;
	logic [TOTAL_W-1:0]   total;
	logic                 zero_res;
	logic [CNT_W-1:0]     divisor;
	logic                 div_busy;
	logic [SCORE_W-1:0]   quotient;
	logic                 gene_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_req_q <= MIN_REQ_RESET;
			square_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_REQUIRED: min_req_q <= cfg_data[MIN_REQ_W-1:0];
				CFG_SQUARE_MODE:  square_q  <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Square-mode term over two multiply stages
	assign dev    = (score_q >= SCORE_W'(SQ_CENTER))
		? {1'b0, score_q} - (SCORE_W + 1)'(SQ_CENTER)
		: (SCORE_W + 1)'(SQ_CENTER) - {1'b0, score_q};
	assign biased = SCORE_W'(dev + (SCORE_W + 1)'(SQ_BIAS));
	assign scaled = prod_q * RECIP_100;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			score_q <= score;
			last_q  <= last;
		end
		if (cmd.sq_mul) begin
			prod_q <= biased * biased;
		end
		if (cmd.sq_div) begin
			term_q <= scaled[RECIP_SHIFT+TERM_W-1:RECIP_SHIFT] + TERM_W'(SQ_OFFSET);
		end
	end

	assign term  = square_q ? term_q : TERM_W'(score_q);
	assign total = TOTAL_W'(sum_q) + TOTAL_W'(term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			nz_q    <= '0;
			items_q <= '0;
			wrap_q  <= 1'b0;
		end else if (cmd.out_load) begin
			sum_q   <= '0;
			nz_q    <= '0;
			items_q <= '0;
			wrap_q  <= 1'b0;
		end else if (cmd.acc && (items_q < CNT_W'(MAX_QUERIES))) begin
			// Drop items beyond the query limit
			items_q <= items_q + 1'b1;
			if (score_q != '0) begin
				sum_q <= total[SCORE_W-1:0];
				nz_q  <= nz_q + 1'b1;
				if (total[TOTAL_W-1:SCORE_W] != '0) begin
					wrap_q <= 1'b1;
				end
			end
		end
	end

	assign zero_res = (nz_q == '0)
		|| ((min_req_q != MIN_REQ_TOTAL) && (MIN_REQ_W'(nz_q) < min_req_q));
	assign divisor  = (min_req_q == MIN_REQ_TOTAL) ? items_q : nz_q;

	msma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			gene_score_q  <= zero_res ? '0 : quotient;
			sum_wrapped_q <= wrap_q;
		end
	end

	assign sts.square   = square_q;
	assign sts.last     = last_q;
	assign sts.zero_res = zero_res;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !res_valid_q || res_ready;

	assign res_valid   = res_valid_q;
	assign gene_score  = gene_score_q;
	assign sum_wrapped = sum_wrapped_q;

	assign gene_clear = (items_q == '0) && (nz_q == '0) && (sum_q == '0) && !wrap_q;

	`MSMA_ASSERT(a_items_bound, items_q <= CNT_W'(MAX_QUERIES), "item count over limit")
	`MSMA_ASSERT(a_nz_le_items, nz_q <= items_q, "nonzero count above item count")
	`MSMA_ASSERT(a_wrap_needs_nz, !wrap_q || (nz_q != '0), "wrap without a nonzero score")
	`MSMA_ASSERT_NEXT(a_clear_on_emit, cmd.out_load, gene_clear, "gene state not cleared")

endmodule

`default_nettype wire

### design/msma_ctrl.sv
`default_nettype none

module msma_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  msma_pkg::msma_sts_t sts,
	output msma_pkg::msma_cmd_t cmd
);
	import msma_pkg::*;

	msma_state_t state_q;
	msma_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_next = sts.square ? ST_SQ_MUL : ST_ACC;
				end
			end
			ST_SQ_MUL: begin
				cmd.sq_mul = 1'b1;
				state_next = ST_SQ_DIV;
			end
			ST_SQ_DIV: begin
				cmd.sq_div = 1'b1;
				state_next = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc    = 1'b1;
				state_next = sts.last ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				// Skip the divide when the result is forced to zero
				if (sts.zero_res) begin
					state_next = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (!sts.div_busy) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Hold until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/masked_score_mean_aggregator.sv
`default_nettype none

// Averages one gene's 16-bit scores; a zero score adds nothing to the sum and
// counts in the divisor only while min_required is 1. The request with last
// closes the gene and yields one result (gene_score, sum_wrapped) held in an
// output register. A request passes IDLE, SQ_MUL and SQ_DIV if square_mode is
// set (two registered multiply stages form the squared term), and ACC; a last
// one then passes CHECK, DIV_WAIT for the bit-serial divider unless the result
// is forced to zero, and EMIT, which stalls while the previous result is unread.
// A waiting result does not block new requests until the next gene ends.
// Configuration writes take effect at once and belong between genes.
module masked_score_mean_aggregator (
	input  logic                            clk,
	input  logic                            arst_n,
	msma_in_if.sink                         in_ch,
	msma_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [msma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msma_pkg::CFG_DATA_W-1:0] cfg_data
);
	import msma_pkg::*;

	msma_cmd_t cmd;
	msma_sts_t sts;

	msma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_ch.valid),
		.req_ready (in_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	msma_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.score       (in_ch.score),
		.last        (in_ch.last),
		.cmd         (cmd),
		.sts         (sts),
		.res_ready   (out_ch.ready),
		.res_valid   (out_ch.valid),
		.gene_score  (out_ch.gene_score),
		.sum_wrapped (out_ch.sum_wrapped)
	);

endmodule

`default_nettype wire
